>>> rtl/rbd_pkg.sv
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types and constants for the ring buffer deque: request and status
// codes, fixed payload widths and the default store geometry.
// ----------------------------------------------------------------------------
package rbd_pkg;

  // Fixed payload widths of the request and response channels.
  localparam int unsigned ReqTypeW = 3;
  localparam int unsigned PushW    = 32;
  localparam int unsigned PosW     = 8;
  localparam int unsigned DataW    = 32;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CountW   = 9;

  // Default store geometry.
  localparam int unsigned DefaultDepth     = 256;
  localparam int unsigned DefaultDataWidth = 32;

  // Request codes.
  typedef enum logic [ReqTypeW-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_READ       = 3'd4,
    REQ_REVERSE    = 3'd5
  } req_type_e;

  // Response status codes.
  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

endpackage

>>> rtl/rbd_if.sv
// ----------------------------------------------------------------------------
// rbd_if
// Valid/ready channels of the ring buffer deque: the request channel and the
// response channel, each with a source and a sink modport.
// ----------------------------------------------------------------------------

// Request channel: one transaction carries one deque request.
interface rbd_req_if;
  logic                                valid;
  logic                                ready;
  logic [rbd_pkg::ReqTypeW-1:0]        req_type;
  logic signed [rbd_pkg::PushW-1:0]    push_value;
  logic [rbd_pkg::PosW-1:0]            position;

  modport source (output valid, output req_type, output push_value, output position,
                  input ready);
  modport sink   (input valid, input req_type, input push_value, input position,
                  output ready);
endinterface

// Response channel: one transaction carries the result of one request.
interface rbd_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [rbd_pkg::DataW-1:0]    data;
  logic [rbd_pkg::StatusW-1:0]         status;
  logic [rbd_pkg::CountW-1:0]          count;

  modport source (output valid, output data, output status, output count,
                  input ready);
  modport sink   (input valid, input data, input status, input count,
                  output ready);
endinterface

>>> rtl/ring_buffer_deque_unit.sv
// ----------------------------------------------------------------------------
// ring_buffer_deque_unit
// Double-ended queue of signed words kept in a single-port ring memory.
// ----------------------------------------------------------------------------
// The deque takes one request per cycle unless a stalled response backs up
// the result stage, and returns exactly one response per request through the
// result stage and the output register. Each request makes at most one
// access to the ring memory in the cycle it is accepted (a write for a push,
// a read for a pop or a positional read), and the memory's read port is
// registered. Reverse only flips the logical order and costs no memory
// access. Error responses (full on push, empty on pop, position at or beyond
// count) leave the contents untouched and return zero data. The store needs
// no clearing after reset: only entries written by a push are ever read.

module ring_buffer_deque_unit #(
  parameter int unsigned DEPTH      = rbd_pkg::DefaultDepth,
  parameter int unsigned DATA_WIDTH = rbd_pkg::DefaultDataWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rbd_req_if.sink     req_i,
  rbd_rsp_if.source   rsp_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = ((AW > rbd_pkg::PosW) ? AW : rbd_pkg::PosW) + 2;

  // Ring memory and its registered read data.
  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  // Pointer state.
  logic [AW-1:0] front_q, front_d;
  logic [AW-1:0] back_q, back_d;
  logic [CW-1:0] count_q, count_d;
  logic          rev_q, rev_d;

  // Memory access of the current request.
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_addr;
  logic [DATA_WIDTH-1:0] mem_wdata;

  // Result stage between the memory and the output register.
  logic                         s1_valid_q;
  logic                         s1_rd_q;
  logic [rbd_pkg::StatusW-1:0]  s1_status_q;
  logic [CW-1:0]                s1_count_q;
  logic                         rd_d;
  rbd_pkg::status_e             status_d;

  // Output register.
  logic                         out_valid_q;
  logic [rbd_pkg::DataW-1:0]    out_data_q;
  logic [rbd_pkg::StatusW-1:0]  out_status_q;
  logic [rbd_pkg::CountW-1:0]   out_count_q;

  logic req_fire, out_free, s1_move;

  // Derived pointer values and helpers.
  logic                  is_full, is_empty, pos_beyond, at_front;
  logic [AW-1:0]         front_inc, front_dec, back_inc, back_dec;
  logic [SW-1:0]         fwd_sum, fwd_idx, rev_sum, rev_idx;
  logic [DATA_WIDTH+rbd_pkg::PushW-1:0] push_ext;
  logic [DATA_WIDTH+rbd_pkg::DataW-1:0] rdata_ext;
  logic [CW+rbd_pkg::CountW-1:0]        count_ext;

  // Handshake: the result stage drains into the output register when it is free.
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign s1_move     = s1_valid_q && out_free;
  assign req_i.ready = !s1_valid_q || out_free;
  assign req_fire    = req_i.valid && req_i.ready;

  // Wrapping pointer steps.
  assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);
  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
  assign back_inc  = (back_q == AW'(DEPTH - 1)) ? '0 : back_q + AW'(1);
  assign back_dec  = (back_q == '0) ? AW'(DEPTH - 1) : back_q - AW'(1);

  assign is_full    = (count_q == CW'(DEPTH));
  assign is_empty   = (count_q == '0);
  assign pos_beyond = ({{CW{1'b0}}, req_i.position} >= {{rbd_pkg::PosW{1'b0}}, count_q});

  // Physical index of a logical position; the sum stays below twice the depth.
  assign fwd_sum = SW'(front_q) + SW'(req_i.position);
  assign fwd_idx = (fwd_sum >= SW'(DEPTH)) ? fwd_sum - SW'(DEPTH) : fwd_sum;
  assign rev_sum = SW'(back_q) + SW'(DEPTH - 1) - SW'(req_i.position);
  assign rev_idx = (rev_sum >= SW'(DEPTH)) ? rev_sum - SW'(DEPTH) : rev_sum;

  // A pushed word keeps its low bits.
  assign push_ext  = {{DATA_WIDTH{1'b0}}, req_i.push_value};
  assign mem_wdata = push_ext[DATA_WIDTH-1:0];

  // Request decode: pointer updates and the single memory access.
  always_comb begin
    front_d  = front_q;
    back_d   = back_q;
    count_d  = count_q;
    rev_d    = rev_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = front_q;
    rd_d     = 1'b0;
    status_d = rbd_pkg::ST_OK;
    at_front = 1'b0;
    case (req_i.req_type)
      rbd_pkg::REQ_PUSH_FRONT, rbd_pkg::REQ_PUSH_BACK: begin
        if (is_full) begin
          status_d = rbd_pkg::ST_FULL;
        end else begin
          at_front = (req_i.req_type == rbd_pkg::REQ_PUSH_FRONT) ^ rev_q;
          mem_we   = 1'b1;
          count_d  = count_q + CW'(1);
          if (at_front) begin
            front_d  = front_dec;
            mem_addr = front_dec;
          end else begin
            back_d   = back_inc;
            mem_addr = back_q;
          end
        end
      end
      rbd_pkg::REQ_POP_FRONT, rbd_pkg::REQ_POP_BACK: begin
        if (is_empty) begin
          status_d = rbd_pkg::ST_EMPTY;
        end else begin
          at_front = (req_i.req_type == rbd_pkg::REQ_POP_FRONT) ^ rev_q;
          mem_re   = 1'b1;
          rd_d     = 1'b1;
          count_d  = count_q - CW'(1);
          if (at_front) begin
            front_d  = front_inc;
            mem_addr = front_q;
          end else begin
            back_d   = back_dec;
            mem_addr = back_dec;
          end
        end
      end
      rbd_pkg::REQ_READ: begin
        if (pos_beyond) begin
          status_d = rbd_pkg::ST_RANGE;
        end else begin
          mem_re   = 1'b1;
          rd_d     = 1'b1;
          mem_addr = rev_q ? rev_idx[AW-1:0] : fwd_idx[AW-1:0];
        end
      end
      rbd_pkg::REQ_REVERSE: begin
        rev_d = !rev_q;
      end
      default: begin
        status_d = rbd_pkg::ST_OK;
      end
    endcase
  end

  // Ring memory: at most one write or one registered read per accepted request.
  always_ff @(posedge clk_i) begin
    if (req_fire && mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    if (req_fire && mem_re) begin
      rdata_q <= mem_q[mem_addr];
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      back_q      <= '0;
      count_q     <= '0;
      rev_q       <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_fire) begin
        front_q <= front_d;
        back_q  <= back_d;
        count_q <= count_d;
        rev_q   <= rev_d;
      end
      if (req_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Sign-extend a stored word and cut it to the response width.
  assign rdata_ext = {{rbd_pkg::DataW{rdata_q[DATA_WIDTH-1]}}, rdata_q};
  assign count_ext = {{rbd_pkg::CountW{1'b0}}, s1_count_q};

  // Result stage and output register payload.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      s1_rd_q     <= rd_d;
      s1_status_q <= status_d;
      s1_count_q  <= count_d;
    end
    if (s1_move) begin
      out_data_q   <= s1_rd_q ? rdata_ext[rbd_pkg::DataW-1:0] : '0;
      out_status_q <= s1_status_q;
      out_count_q  <= count_ext[rbd_pkg::CountW-1:0];
    end
  end

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.data   = out_data_q;
  assign rsp_o.status = out_status_q;
  assign rsp_o.count  = out_count_q;

endmodule

>>> rtl/rbd_checker.sv
// ----------------------------------------------------------------------------
// rbd_checker
// Port-level checks of the ring buffer deque responses, bound to ring_buffer_deque_unit.
// ----------------------------------------------------------------------------
module rbd_checker #(
  parameter int unsigned DEPTH = rbd_pkg::DefaultDepth
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [rbd_pkg::DataW-1:0]     rsp_data_i,
  input logic [rbd_pkg::StatusW-1:0]   rsp_status_i,
  input logic [rbd_pkg::CountW-1:0]    rsp_count_i
);

  // A push refused as full reports a full deque.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && rsp_status_i == rbd_pkg::ST_FULL) |-> rsp_count_i == 9'(DEPTH))
    else $error("full response with count other than the depth");

  // A pop refused as empty reports an empty deque.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && rsp_status_i == rbd_pkg::ST_EMPTY) |-> rsp_count_i == '0)
    else $error("empty response with nonzero count");

  // Every error response carries zero data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && rsp_status_i != rbd_pkg::ST_OK) |-> rsp_data_i == '0)
    else $error("error response with nonzero data");

  // A stalled response transaction holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(rsp_data_i) && $stable(rsp_status_i) && $stable(rsp_count_i)))
    else $error("stalled response changed");

endmodule

bind ring_buffer_deque_unit rbd_checker #(.DEPTH(DEPTH)) u_rbd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_data_i   (rsp_o.data),
  .rsp_status_i (rsp_o.status),
  .rsp_count_i  (rsp_o.count)
);
